// ===== rtl/ctcgd_pkg.sv =====
package ctcgd_pkg;

  localparam int unsigned IdxW       = 13;
  localparam int unsigned ProbW      = 16;
  localparam int unsigned SumW       = 24;
  localparam int unsigned CountW     = 8;
  localparam int unsigned NumClasses = 8192;
  localparam int unsigned QueueDepth = 2;

  // dividend is sum plus half the count, one bit wider than the sum
  localparam int unsigned DivW      = SumW + 1;
  localparam int unsigned DivCntW   = $clog2(DivW + 1);

  localparam logic [IdxW-1:0]   ClassLast = IdxW'(NumClasses - 1);
  localparam logic [IdxW-1:0]   BlankIdx  = '0;
  localparam logic [CountW-1:0] CountMax  = '1;

  localparam logic KindChar  = 1'b0;
  localparam logic KindFinal = 1'b1;

  // one queue entry: what a closed timestep and/or sequence leaves to do
  typedef struct packed {
    logic              has_char;
    logic [IdxW-1:0]   char_index;
    logic              has_final;
    logic [SumW-1:0]   score_sum;
    logic [CountW-1:0] kept_count;
  } cmd_t;

  typedef enum logic [3:0] {
    BackIdle  = 4'b0001,
    BackChar  = 4'b0010,
    BackDiv   = 4'b0100,
    BackFinal = 4'b1000
  } back_state_e;

endpackage

// ===== rtl/ctcgd_front.sv =====
module ctcgd_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [ctcgd_pkg::ProbW-1:0]          prob_i,
  input  logic                                 end_of_step_i,
  input  logic                                 end_of_sequence_i,
  output logic                                 push_o,
  output ctcgd_pkg::cmd_t                      cmd_o
);

  logic [ctcgd_pkg::IdxW-1:0]   class_cnt_q, class_cnt_d;
  logic [ctcgd_pkg::ProbW-1:0]  best_val_q, best_val_d;
  logic [ctcgd_pkg::IdxW-1:0]   best_idx_q, best_idx_d;
  logic [ctcgd_pkg::IdxW-1:0]   prev_idx_q, prev_idx_d;
  logic [ctcgd_pkg::SumW-1:0]   sum_q, sum_d;
  logic [ctcgd_pkg::CountW-1:0] kept_q, kept_d;

  logic                         step_end;
  logic                         take;
  logic                         keep;
  logic [ctcgd_pkg::ProbW-1:0]  cur_val;
  logic [ctcgd_pkg::IdxW-1:0]   cur_idx;
  logic [ctcgd_pkg::SumW-1:0]   new_sum;
  logic [ctcgd_pkg::CountW-1:0] new_kept;

  assign step_end = end_of_step_i | end_of_sequence_i;
  // first maximum wins: only a strictly larger value replaces it
  assign take     = (class_cnt_q == '0) || (prob_i > best_val_q);
  assign cur_val  = take ? prob_i : best_val_q;
  assign cur_idx  = take ? class_cnt_q : best_idx_q;
  assign keep     = step_end && (cur_idx != ctcgd_pkg::BlankIdx) &&
                    (cur_idx != prev_idx_q) && (kept_q != ctcgd_pkg::CountMax);
  assign new_sum  = keep ? sum_q + ctcgd_pkg::SumW'(cur_val) : sum_q;
  assign new_kept = keep ? kept_q + 1'b1 : kept_q;

  assign push_o           = accept_i && (keep || end_of_sequence_i);
  assign cmd_o.has_char   = keep;
  assign cmd_o.char_index = cur_idx;
  assign cmd_o.has_final  = end_of_sequence_i;
  assign cmd_o.score_sum  = new_sum;
  assign cmd_o.kept_count = new_kept;

  always_comb begin
    class_cnt_d = class_cnt_q;
    best_val_d  = best_val_q;
    best_idx_d  = best_idx_q;
    prev_idx_d  = prev_idx_q;
    sum_d       = sum_q;
    kept_d      = kept_q;
    if (accept_i) begin
      priority if (end_of_sequence_i) begin
        class_cnt_d = '0;
        best_val_d  = '0;
        best_idx_d  = '0;
        prev_idx_d  = '0;
        sum_d       = '0;
        kept_d      = '0;
      end else if (step_end) begin
        class_cnt_d = '0;
        best_val_d  = '0;
        best_idx_d  = '0;
        prev_idx_d  = cur_idx;
        sum_d       = new_sum;
        kept_d      = new_kept;
      end else begin
        best_val_d  = cur_val;
        best_idx_d  = cur_idx;
        // surplus classes all count as the last class
        if (class_cnt_q != ctcgd_pkg::ClassLast) begin
          class_cnt_d = class_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_cnt_q <= '0;
      best_val_q  <= '0;
      best_idx_q  <= '0;
      prev_idx_q  <= '0;
      sum_q       <= '0;
      kept_q      <= '0;
    end else begin
      class_cnt_q <= class_cnt_d;
      best_val_q  <= best_val_d;
      best_idx_q  <= best_idx_d;
      prev_idx_q  <= prev_idx_d;
      sum_q       <= sum_d;
      kept_q      <= kept_d;
    end
  end

endmodule

// ===== rtl/ctcgd_queue.sv =====
module ctcgd_queue #(
  parameter int unsigned Depth = ctcgd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ctcgd_pkg::cmd_t push_cmd_i,
  input  logic            pop_i,
  output ctcgd_pkg::cmd_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ctcgd_pkg::cmd_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntFull);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/ctcgd_back.sv =====
module ctcgd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ctcgd_pkg::cmd_t                     head_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                kind_o,
  output logic [ctcgd_pkg::IdxW-1:0]          char_index_o,
  output logic [ctcgd_pkg::ProbW-1:0]         mean_score_o,
  output logic [ctcgd_pkg::CountW-1:0]        char_count_o,
  output logic                                empty_res_o,
  output logic                                last_o
);

  localparam int unsigned DivW    = ctcgd_pkg::DivW;
  localparam int unsigned RemW    = ctcgd_pkg::CountW + 1;
  localparam int unsigned ProbW   = ctcgd_pkg::ProbW;
  localparam int unsigned DivCntW = ctcgd_pkg::DivCntW;
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivW - 1);

  ctcgd_pkg::back_state_e state_q, state_d;

  logic                           has_final_q;
  logic [ctcgd_pkg::IdxW-1:0]     char_q;
  logic [ctcgd_pkg::CountW-1:0]   count_q;
  logic [DivW-1:0]                num_q;
  logic [DivW-1:0]                quo_q;
  logic [RemW-1:0]                rem_q;
  logic [DivCntW-1:0]             step_q;

  logic                           out_free;
  logic                           load_char;
  logic                           load_final;
  logic [RemW-1:0]                rem_sh;
  logic                           fits;
  logic [ProbW-1:0]               mean;
  logic                           after_pop_div;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign pop_o      = (state_q == ctcgd_pkg::BackIdle) && !empty_i;
  assign load_char  = (state_q == ctcgd_pkg::BackChar) && out_free;
  assign load_final = (state_q == ctcgd_pkg::BackFinal) && out_free;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q[RemW-2:0], num_q[DivW-1]};
  assign fits   = rem_sh >= {1'b0, count_q};
  assign mean   = (quo_q[DivW-1:ProbW] != '0) ? '1 : quo_q[ProbW-1:0];
  assign after_pop_div = head_i.kept_count != '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ctcgd_pkg::BackIdle: begin
        if (!empty_i) begin
          priority if (head_i.has_char) state_d = ctcgd_pkg::BackChar;
          else if (after_pop_div)       state_d = ctcgd_pkg::BackDiv;
          else                          state_d = ctcgd_pkg::BackFinal;
        end
      end
      ctcgd_pkg::BackChar: begin
        if (out_free) begin
          priority if (!has_final_q)  state_d = ctcgd_pkg::BackIdle;
          else if (count_q != '0)     state_d = ctcgd_pkg::BackDiv;
          else                        state_d = ctcgd_pkg::BackFinal;
        end
      end
      ctcgd_pkg::BackDiv: begin
        if (step_q == DivLast) state_d = ctcgd_pkg::BackFinal;
      end
      ctcgd_pkg::BackFinal: begin
        if (out_free) state_d = ctcgd_pkg::BackIdle;
      end
      default: state_d = ctcgd_pkg::BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ctcgd_pkg::BackIdle;
      out_valid_o <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_char || load_final) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == ctcgd_pkg::BackDiv) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      has_final_q <= head_i.has_final;
      char_q      <= head_i.char_index;
      count_q     <= head_i.kept_count;
      num_q       <= DivW'(head_i.score_sum) + DivW'(head_i.kept_count >> 1);
      quo_q       <= '0;
      rem_q       <= '0;
    end else if (state_q == ctcgd_pkg::BackDiv) begin
      num_q <= {num_q[DivW-2:0], 1'b0};
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= fits ? rem_sh - {1'b0, count_q} : rem_sh;
    end
    if (load_char) begin
      kind_o       <= ctcgd_pkg::KindChar;
      char_index_o <= char_q;
      mean_score_o <= '0;
      char_count_o <= '0;
      empty_res_o  <= 1'b0;
      last_o       <= 1'b0;
    end else if (load_final) begin
      kind_o       <= ctcgd_pkg::KindFinal;
      char_index_o <= '0;
      mean_score_o <= (count_q == '0) ? '0 : mean;
      char_count_o <= count_q;
      empty_res_o  <= (count_q == '0);
      last_o       <= 1'b1;
    end
  end

endmodule

// ===== rtl/ctc_greedy_decoder_top.sv =====
// channel | direction | handshake                  | payload
// in      | input     | in_valid_i / in_stall_o    | prob_i, end_of_step_i, end_of_sequence_i
// out     | output    | out_valid_o / out_stall_i  | kind_o, char_index_o, mean_score_o,
//         |           |                            | char_count_o, empty_res_o, last_o
//
// One probability per cycle while in_stall_o is low; in_stall_o rises only while the command queue is full.
// In the back end a character result is loaded from the character state; a final result
// is loaded from the final state, after the bit-serial mean divider when characters were kept.
// Reset (rst_ni low, async) clears all step/sequence state and empties the queue.
// Output is registered; out_stall_i holds it and backs up into the queue.
module ctc_greedy_decoder_top #(
  parameter int unsigned QueueDepth = ctcgd_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ctcgd_pkg::ProbW-1:0]         prob_i,
  input  logic                                end_of_step_i,
  input  logic                                end_of_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                kind_o,
  output logic [ctcgd_pkg::IdxW-1:0]          char_index_o,
  output logic [ctcgd_pkg::ProbW-1:0]         mean_score_o,
  output logic [ctcgd_pkg::CountW-1:0]        char_count_o,
  output logic                                empty_res_o,
  output logic                                last_o
);

  logic            in_accept;
  logic            q_push, q_pop, q_empty, q_full;
  ctcgd_pkg::cmd_t push_cmd, head_cmd;

  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  ctcgd_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i          (in_accept),
    .prob_i,
    .end_of_step_i,
    .end_of_sequence_i,
    .push_o            (q_push),
    .cmd_o             (push_cmd)
  );

  ctcgd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  ctcgd_back u_back (
    .clk_i,
    .rst_ni,
    .head_i       (head_cmd),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .char_index_o,
    .mean_score_o,
    .char_count_o,
    .empty_res_o,
    .last_o
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_char_not_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == ctcgd_pkg::KindChar)) |-> (char_index_o != '0))
    else $error("blank class emitted as character");

  a_empty_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (mean_score_o == '0 && char_count_o == '0 && last_o))
    else $error("empty final result carries a score");

endmodule
